// ----- src/two_level_page_table_walker_defines.svh -----
// Assertion macros shared by the page table walker checker.
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define TLPTW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("page table walker assertion failed");

// Clocked assertion that is also checked during reset.
`define TLPTW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("page table walker assertion failed");

`endif

// ----- src/tlptw_pkg.sv -----
// Types and constants of the two-level page table walker.
package tlptw_pkg;

   localparam int unsigned AddrWidth   = 32;
   localparam int unsigned PpnWidth    = 22;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned FaultWidth  = 3;
   localparam int unsigned PhaseWidth  = 2;

   localparam logic [PhaseWidth-1:0] PHASE_IDLE = 2'd0;
   localparam logic [PhaseWidth-1:0] PHASE_L1   = 2'd1;
   localparam logic [PhaseWidth-1:0] PHASE_L2   = 2'd2;

   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_RESPONSE  = 1'b1;

   localparam logic [KindWidth-1:0] KIND_READ  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_DONE  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_FAULT = 2'd2;

   localparam logic [FaultWidth-1:0] FAULT_NONE        = 3'd0;
   localparam logic [FaultWidth-1:0] FAULT_L1_INVALID  = 3'd1;
   localparam logic [FaultWidth-1:0] FAULT_L1_LEAF     = 3'd2;
   localparam logic [FaultWidth-1:0] FAULT_L2_INVALID  = 3'd3;
   localparam logic [FaultWidth-1:0] FAULT_L2_NOT_LEAF = 3'd4;

   localparam int unsigned PTE_V = 0;
   localparam int unsigned PTE_R = 1;
   localparam int unsigned PTE_W = 2;
   localparam int unsigned PTE_X = 3;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [AddrWidth-1:0]  address;
      logic [FaultWidth-1:0] fault_code;
   } rsp_item_type;

endpackage

// ----- src/two_level_page_table_walker.sv -----
// Two-level page table walker with a registered, skid-buffered result channel.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_cmd, req_virt_addr, req_mem_data
//   rsp      out        rsp_valid/rsp_ready    rsp_kind, rsp_address, rsp_fault_code
//   csr      in         csr_valid/csr_ready    csr_table_ppn
//
// Every input transfer is handled combinationally and its result is registered.
// The sustained rate is one item per cycle from request to result while req_ready is high.
// A skid register keeps req_ready high for one more transfer while a result is stalled.
// Synchronous reset returns the walk to idle, empties both result slots and clears the
// first-level table page number.
module two_level_page_table_walker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [tlptw_pkg::AddrWidth-1:0]     req_virt_addr,
   input  logic [tlptw_pkg::AddrWidth-1:0]     req_mem_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tlptw_pkg::KindWidth-1:0]     rsp_kind,
   output logic [tlptw_pkg::AddrWidth-1:0]     rsp_address,
   output logic [tlptw_pkg::FaultWidth-1:0]    rsp_fault_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlptw_pkg::PpnWidth-1:0]      csr_table_ppn
);

   logic [tlptw_pkg::PhaseWidth-1:0] phase_ff, phase_in;
   logic [tlptw_pkg::AddrWidth-1:0]  vaddr_ff, vaddr_in;
   logic [tlptw_pkg::PpnWidth-1:0]   table_ppn_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   tlptw_pkg::rsp_item_type          rsp_data_ff, rsp_data_in;
   logic                             skid_valid_ff, skid_valid_in;
   tlptw_pkg::rsp_item_type          skid_data_ff, skid_data_in;

   logic                    in_fire;
   logic                    res_push;
   tlptw_pkg::rsp_item_type res;
   logic                    pte_valid;
   logic                    pte_leaf;
   logic                    main_free;

   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign in_fire   = req_valid && req_ready;
   assign main_free = !rsp_valid_ff || rsp_ready;

   assign pte_valid = req_mem_data[tlptw_pkg::PTE_V];
   assign pte_leaf  = req_mem_data[tlptw_pkg::PTE_R] || req_mem_data[tlptw_pkg::PTE_W]
                      || req_mem_data[tlptw_pkg::PTE_X];

   always_comb begin
      phase_in       = phase_ff;
      vaddr_in       = vaddr_ff;
      res_push       = 1'b0;
      res.kind       = tlptw_pkg::KIND_FAULT;
      res.address    = '0;
      res.fault_code = tlptw_pkg::FAULT_NONE;
      if (in_fire) begin
         if (req_cmd == tlptw_pkg::CMD_TRANSLATE) begin
            if (phase_ff == tlptw_pkg::PHASE_IDLE) begin
               vaddr_in    = req_virt_addr;
               phase_in    = tlptw_pkg::PHASE_L1;
               res_push    = 1'b1;
               res.kind    = tlptw_pkg::KIND_READ;
               res.address = {table_ppn_ff[19:0], req_virt_addr[31:22], 2'b00};
            end
         end else begin
            case (phase_ff)
               tlptw_pkg::PHASE_L1: begin
                  res_push = 1'b1;
                  if (!pte_valid) begin
                     phase_in       = tlptw_pkg::PHASE_IDLE;
                     res.fault_code = tlptw_pkg::FAULT_L1_INVALID;
                  end else if (pte_leaf) begin
                     phase_in       = tlptw_pkg::PHASE_IDLE;
                     res.fault_code = tlptw_pkg::FAULT_L1_LEAF;
                  end else begin
                     phase_in    = tlptw_pkg::PHASE_L2;
                     res.kind    = tlptw_pkg::KIND_READ;
                     res.address = {req_mem_data[29:10], vaddr_ff[21:12], 2'b00};
                  end
               end
               tlptw_pkg::PHASE_L2: begin
                  res_push = 1'b1;
                  phase_in = tlptw_pkg::PHASE_IDLE;
                  if (!pte_valid) begin
                     res.fault_code = tlptw_pkg::FAULT_L2_INVALID;
                  end else if (!pte_leaf) begin
                     res.fault_code = tlptw_pkg::FAULT_L2_NOT_LEAF;
                  end else begin
                     res.kind    = tlptw_pkg::KIND_DONE;
                     res.address = {req_mem_data[29:10], vaddr_ff[11:0]};
                  end
               end
               default: begin
                  res_push = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = res_push;
            rsp_data_in  = res;
         end
      end else if (res_push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tlptw_pkg::PHASE_IDLE;
         vaddr_ff      <= '0;
         table_ppn_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         vaddr_ff      <= vaddr_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_valid && csr_ready) begin
            table_ppn_ff <= csr_table_ppn;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_data_ff.kind;
   assign rsp_address    = rsp_data_ff.address;
   assign rsp_fault_code = rsp_data_ff.fault_code;

endmodule

// ----- src/tlptw_checker.sv -----
// Port-level checker for the page table walker and its bind statement.
`include "two_level_page_table_walker_defines.svh"

module tlptw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tlptw_pkg::KindWidth-1:0]  rsp_kind,
   input logic [tlptw_pkg::AddrWidth-1:0]  rsp_address,
   input logic [tlptw_pkg::FaultWidth-1:0] rsp_fault_code
);

   logic [tlptw_pkg::KindWidth+tlptw_pkg::AddrWidth+tlptw_pkg::FaultWidth-1:0] rsp_payload;
   logic rsp_stall;
   logic rsp_fault;
   logic rsp_read;
   logic rsp_other;
   logic rsp_code_none;
   logic fault_code_known;

   assign rsp_payload      = {rsp_kind, rsp_address, rsp_fault_code};
   assign rsp_stall        = rsp_valid && !rsp_ready;
   assign rsp_fault        = rsp_valid && (rsp_kind == tlptw_pkg::KIND_FAULT);
   assign rsp_read         = rsp_valid && (rsp_kind == tlptw_pkg::KIND_READ);
   assign rsp_other        = rsp_valid && (rsp_kind != tlptw_pkg::KIND_FAULT);
   assign rsp_code_none    = rsp_fault_code == tlptw_pkg::FAULT_NONE;
   assign fault_code_known = (rsp_fault_code == tlptw_pkg::FAULT_L1_INVALID)
                             || (rsp_fault_code == tlptw_pkg::FAULT_L1_LEAF)
                             || (rsp_fault_code == tlptw_pkg::FAULT_L2_INVALID)
                             || (rsp_fault_code == tlptw_pkg::FAULT_L2_NOT_LEAF);

   // A stalled result transfer keeps its payload.
   `TLPTW_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // Only faults carry a fault code.
   `TLPTW_ASSERT(a_code_only_on_fault, clock, reset, rsp_other |-> rsp_code_none)

   // A fault has a zero address and one of the four defined codes.
   `TLPTW_ASSERT(a_fault_shape, clock, reset, rsp_fault |-> rsp_address == '0 && fault_code_known)

   // Entry read requests are always word aligned.
   `TLPTW_ASSERT(a_read_aligned, clock, reset, rsp_read |-> rsp_address[1:0] == 2'b00)

   // Reset leaves the result channel empty.
   `TLPTW_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind two_level_page_table_walker tlptw_checker u_tlptw_checker (.*);
